// File: rtl/core/afd_pkg.sv
// shared types and constants for the accelerometer fall detector
package afd_pkg;

  localparam int MAG_W      = 16;
  localparam int RADICAND_W = 2 * MAG_W;
  localparam int THRESH_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SQRT_STEPS = MAG_W;
  localparam int DIV_STEPS  = MAG_W;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;

  localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RESET  = 16'd2048;
  localparam logic [THRESH_W-1:0] HIGH_THRESHOLD_RESET = 16'd7373;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

endpackage

// File: rtl/core/accel_magnitude_fall_detector_core.sv
// top level of the accelerometer magnitude fall detector
// Each sample beat yields one result beat. After acceptance the three axes are squared and
// added through one shared 16x16 multiplier. ROOT_GO starts the serial square-root unit,
// which then runs one root bit per cycle and signals done. SUM updates the ring and the
// running sum, DIV_GO starts the serial divide by WINDOW, which also signals done when
// finished, and OUT loads the output register. The next sample is taken the cycle after
// the result is loaded into the output register, which holds it until it is taken. So no
// sample is accepted while the previous one is still in flight, and a result beat still
// waiting when the next one is ready holds the block until it is taken. The ring of WINDOW
// magnitudes sits in a memory with one valid flop per entry, so reset clears it at once
// with no clearing pass; an entry not yet written reads as zero. Thresholds are written
// through the cfg port; the user must write them only while the block is idle, as the
// block itself does not enforce it; an unknown index is ignored.
module accel_magnitude_fall_detector_core #(
  parameter int WINDOW = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [afd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afd_pkg::THRESH_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                accel_x,
  input  logic signed [15:0]                accel_y,
  input  logic signed [15:0]                accel_z,
  input  logic                              timeout_flag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              phase,
  output logic                              fall_detected,
  output logic [afd_pkg::MAG_W-1:0]         mean_magnitude
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = afd_pkg::MAG_W + SLOT_W;
  localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'(WINDOW * 65535);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  afd_pkg::state_t state, state_next;

  logic [afd_pkg::THRESH_W-1:0]   low_threshold;
  logic [afd_pkg::THRESH_W-1:0]   high_threshold;

  logic signed [15:0]             x_q, y_q, z_q;
  logic                           timeout_q;
  logic [1:0]                     sq_cnt;
  logic signed [15:0]             axis;
  logic signed [31:0]             product;
  logic [afd_pkg::RADICAND_W-1:0] sq_sum;

  logic [afd_pkg::MAG_W-1:0]      ring [WINDOW];
  logic [WINDOW-1:0]              ring_valid;
  logic [afd_pkg::MAG_W-1:0]      ring_q;
  logic                           ring_valid_q;
  logic [afd_pkg::MAG_W-1:0]      oldest;
  logic [SLOT_W-1:0]              write_slot;
  logic [SUM_W-1:0]               window_sum;
  logic                           detector_phase;

  logic                           root_start, div_start, out_load;
  logic [afd_pkg::MAG_W-1:0]      mag;
  logic [afd_pkg::MAG_W-1:0]      mean;
  afd_pkg::unit_stat_t            root_stat, div_stat;

  logic                           in_pre, fall, phase_next;

  afd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sq_sum),
    .root     (mag),
    .stat     (root_stat)
  );

  afd_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum),
    .quotient (mean),
    .stat     (div_stat)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= afd_pkg::LOW_THRESHOLD_RESET;
      high_threshold <= afd_pkg::HIGH_THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        afd_pkg::REG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        afd_pkg::REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      afd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = afd_pkg::ST_SQUARE;
      end
      afd_pkg::ST_SQUARE: begin
        if (sq_cnt == 2'd3) state_next = afd_pkg::ST_ROOT_GO;
      end
      afd_pkg::ST_ROOT_GO: begin
        root_start = 1'b1;
        state_next = afd_pkg::ST_ROOT_WAIT;
      end
      afd_pkg::ST_ROOT_WAIT: begin
        if (root_stat.done) state_next = afd_pkg::ST_SUM;
      end
      afd_pkg::ST_SUM: begin
        state_next = afd_pkg::ST_DIV_GO;
      end
      afd_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = afd_pkg::ST_DIV_WAIT;
      end
      afd_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) state_next = afd_pkg::ST_OUT;
      end
      afd_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = afd_pkg::ST_IDLE;
        end
      end
      default: state_next = afd_pkg::ST_IDLE;
    endcase
  end

  // sample capture and sum of squares, one axis per cycle
  always_comb begin
    unique case (sq_cnt)
      2'd0:    axis = x_q;
      2'd1:    axis = y_q;
      default: axis = z_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_q       <= accel_x;
      y_q       <= accel_y;
      z_q       <= accel_z;
      timeout_q <= timeout_flag;
      sq_cnt    <= 2'd0;
      sq_sum    <= '0;
    end else if (state == afd_pkg::ST_SQUARE) begin
      sq_cnt  <= sq_cnt + 2'd1;
      product <= 32'(axis) * 32'(axis);
      if (sq_cnt != 2'd0) sq_sum <= sq_sum + unsigned'(product);
    end
  end

  // ring memory; the slot advances only at the ring update of each item
  always_ff @(posedge clk) begin
    ring_q <= ring[write_slot];
    if (state == afd_pkg::ST_SUM) ring[write_slot] <= mag;
  end

  assign oldest = ring_valid_q ? ring_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid     <= '0;
      ring_valid_q   <= 1'b0;
      write_slot     <= '0;
      window_sum     <= '0;
      detector_phase <= 1'b0;
    end else begin
      ring_valid_q <= ring_valid[write_slot];
      if (state == afd_pkg::ST_SUM) begin
        ring_valid[write_slot] <= 1'b1;
        window_sum <= window_sum - SUM_W'(oldest) + SUM_W'(mag);
        write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      end
      if (out_load) detector_phase <= phase_next;
    end
  end

  // idle may drop into pre-fall and be checked against the same mean
  assign in_pre     = detector_phase || (mean < low_threshold);
  assign fall       = in_pre && (mean > high_threshold);
  assign phase_next = in_pre && !fall && !timeout_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      phase          <= phase_next;
      fall_detected  <= fall;
      mean_magnitude <= mean;
    end
  end

`ifndef SYNTHESIS
  a_units_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !root_stat.busy && !div_stat.busy)
    else $error("sample taken while a serial unit is busy");

  a_root_done_state: assert property (@(posedge clk) disable iff (rst)
    root_stat.done |-> state == afd_pkg::ST_ROOT_WAIT)
    else $error("square root finished outside its wait state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == afd_pkg::ST_DIV_WAIT)
    else $error("divide finished outside its wait state");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    window_sum <= SUM_MAX)
    else $error("window sum beyond the window of full-scale magnitudes");

  a_fall_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && fall |=> !detector_phase && !phase)
    else $error("fall beat did not return the detector to idle");
`endif

endmodule

// File: rtl/core/afd_isqrt.sv
// digit-serial integer square root, one root bit per cycle
module afd_isqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [afd_pkg::RADICAND_W-1:0]     radicand,
  output logic [afd_pkg::MAG_W-1:0]          root,
  output afd_pkg::unit_stat_t                stat
);

  localparam int CNT_W = $clog2(afd_pkg::SQRT_STEPS);
  localparam int REM_W = afd_pkg::MAG_W + 3;

  logic [CNT_W-1:0]                 cnt;
  logic [afd_pkg::RADICAND_W-1:0]   rad_sr;
  logic [REM_W-1:0]                 rem;
  logic [REM_W-1:0]                 rem_shift;
  logic [REM_W-1:0]                 trial;
  logic                             take;

  // remainder never exceeds twice the partial root, so its low bits suffice
  assign rem_shift = {rem[REM_W-3:0], rad_sr[afd_pkg::RADICAND_W-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign take      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(afd_pkg::SQRT_STEPS - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sr <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (stat.busy) begin
      rad_sr <= {rad_sr[afd_pkg::RADICAND_W-3:0], 2'b00};
      if (take) begin
        rem  <= rem_shift - trial;
        root <= {root[afd_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[afd_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/afd_div.sv
// bit-serial division of the window sum by the window length
module afd_div #(
  parameter int WINDOW = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [afd_pkg::MAG_W+$clog2(WINDOW)-1:0]  dividend,
  output logic [afd_pkg::MAG_W-1:0]                 quotient,
  output afd_pkg::unit_stat_t                       stat
);

  localparam int RW    = $clog2(WINDOW);
  localparam int SUM_W = afd_pkg::MAG_W + RW;
  localparam int CNT_W = $clog2(afd_pkg::DIV_STEPS);
  localparam logic [RW:0] DIVISOR = (RW+1)'(WINDOW);

  logic [CNT_W-1:0]          cnt;
  logic [RW-1:0]             r;
  logic [afd_pkg::MAG_W-1:0] low_sr;
  logic [RW:0]               t;
  logic                      take;

  assign t    = {r, low_sr[afd_pkg::MAG_W-1]};
  assign take = t >= DIVISOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(afd_pkg::DIV_STEPS - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // the upper bits of the sum are already below the divisor, so only the
  // sixteen quotient bits need a step each
  always_ff @(posedge clk) begin
    if (start) begin
      r        <= dividend[SUM_W-1:afd_pkg::MAG_W];
      low_sr   <= dividend[afd_pkg::MAG_W-1:0];
      quotient <= '0;
    end else if (stat.busy) begin
      low_sr <= {low_sr[afd_pkg::MAG_W-2:0], 1'b0};
      if (take) begin
        r        <= RW'(t - DIVISOR);
        quotient <= {quotient[afd_pkg::MAG_W-2:0], 1'b1};
      end else begin
        r        <= t[RW-1:0];
        quotient <= {quotient[afd_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: tb/fall_detect_checker.sv
// checker for the fall detector: predicts each result beat and compares it with the block
module fall_detect_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [afd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afd_pkg::THRESH_W-1:0]  cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [15:0]            accel_x,
  input  logic signed [15:0]            accel_y,
  input  logic signed [15:0]            accel_z,
  input  logic                          timeout_flag,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          phase,
  input  logic                          fall_detected,
  input  logic [afd_pkg::MAG_W-1:0]     mean_magnitude,
  output int                            errors,
  output int                            outstanding
);

  localparam int WINDOW = 32;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int REPORT_LIMIT = 10;

  typedef enum logic {
    PH_IDLE     = 1'b0,
    PH_PRE_FALL = 1'b1
  } det_phase_t;

  typedef struct packed {
    logic                      ph;
    logic                      fall;
    logic [afd_pkg::MAG_W-1:0] mean;
  } fall_result_t;

  logic [afd_pkg::THRESH_W-1:0] low_thr;
  logic [afd_pkg::THRESH_W-1:0] high_thr;
  logic [afd_pkg::MAG_W-1:0]    mag_ring [WINDOW];
  logic [SLOT_W-1:0]            slot;
  logic [20:0]                  win_sum;
  det_phase_t                   det_ph;
  fall_result_t                 expected_results[$];
  int                           mismatches = 0;
  int                           result_beats = 0;

  // bit-serial floor square root, two radicand bits per step
  function automatic logic [afd_pkg::MAG_W-1:0] int_sqrt(input logic [31:0] radicand);
    logic [32:0] rem;
    logic [32:0] root;
    logic [32:0] bitv;
    rem  = {1'b0, radicand};
    root = '0;
    bitv = 33'h0_4000_0000;
    for (int i = 0; i < 16; i++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[afd_pkg::MAG_W-1:0];
  endfunction

  task automatic advance_window(input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic signed [15:0] z, input logic tmo);
    logic signed [31:0]        sqx;
    logic signed [31:0]        sqy;
    logic signed [31:0]        sqz;
    logic [33:0]               energy;
    logic [afd_pkg::MAG_W-1:0] mag;
    logic [afd_pkg::MAG_W-1:0] mean;
    logic                      fall;
    fall_result_t              res;
    sqx    = 32'(x) * 32'(x);
    sqy    = 32'(y) * 32'(y);
    sqz    = 32'(z) * 32'(z);
    energy = 34'(sqx) + 34'(sqy) + 34'(sqz);
    mag    = int_sqrt(energy[31:0]);
    win_sum = win_sum - 21'(mag_ring[slot]) + 21'(mag);
    mag_ring[slot] = mag;
    slot = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
    mean = afd_pkg::MAG_W'(win_sum / WINDOW);
    fall = 1'b0;
    // idle may enter pre-fall and then be judged on the same mean
    if (det_ph == PH_IDLE && mean < low_thr) det_ph = PH_PRE_FALL;
    if (det_ph == PH_PRE_FALL) begin
      if (mean > high_thr) begin
        fall   = 1'b1;
        det_ph = PH_IDLE;
      end else if (tmo) begin
        det_ph = PH_IDLE;
      end
    end
    res.ph   = det_ph;
    res.fall = fall;
    res.mean = mean;
    expected_results.push_back(res);
  endtask

  task automatic check_result();
    fall_result_t want;
    result_beats++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result beat %0d with nothing expected: phase %0b fall %0b mean %0d",
                 result_beats, phase, fall_detected, mean_magnitude);
    end else begin
      want = expected_results.pop_front();
      if (want.ph !== phase || want.fall !== fall_detected || want.mean !== mean_magnitude) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result beat %0d: expected phase %0b fall %0b mean %0d, got %0b %0b %0d",
                   result_beats, want.ph, want.fall, want.mean,
                   phase, fall_detected, mean_magnitude);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      low_thr  = afd_pkg::LOW_THRESHOLD_RESET;
      high_thr = afd_pkg::HIGH_THRESHOLD_RESET;
      for (int i = 0; i < WINDOW; i++) mag_ring[i] = '0;
      slot    = '0;
      win_sum = '0;
      det_ph  = PH_IDLE;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) advance_window(accel_x, accel_y, accel_z, timeout_flag);
      if (cfg_write) begin
        case (cfg_index)
          afd_pkg::REG_LOW_THRESHOLD:  low_thr = cfg_data;
          afd_pkg::REG_HIGH_THRESHOLD: high_thr = cfg_data;
          default: ;
        endcase
      end
    end
    errors      <= mismatches;
    outstanding <= expected_results.size();
  end

endmodule

// File: tb/accel_magnitude_fall_detector_core_tb.sv
// testbench top for the accelerometer fall detector: stimulus, pacing and verdict
module accel_magnitude_fall_detector_core_tb;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 400;

  // indexes past the last register, written only to see them ignored
  localparam logic [afd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [afd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {SK_REST, SK_FREEFALL, SK_IMPACT, SK_WILD} sample_kind_t;
  typedef enum int {TMO_RARE, TMO_HALF, TMO_ALWAYS} tmo_mode_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [afd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [afd_pkg::THRESH_W-1:0]  cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [15:0]            accel_x = '0;
  logic signed [15:0]            accel_y = '0;
  logic signed [15:0]            accel_z = '0;
  logic                          timeout_flag = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          phase;
  logic                          fall_detected;
  logic [afd_pkg::MAG_W-1:0]     mean_magnitude;

  int errors;
  int outstanding;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 1;
  int items_left = 0;
  bit hold_done = 1'b0;

  accel_magnitude_fall_detector_core #(.WINDOW(32)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .timeout_flag(timeout_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .phase(phase), .fall_detected(fall_detected), .mean_magnitude(mean_magnitude)
  );

  fall_detect_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .timeout_flag(timeout_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .phase(phase), .fall_detected(fall_detected), .mean_magnitude(mean_magnitude),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL accel_magnitude_fall_detector_core");
      $finish;
    end
  end

  // receiver: stretches of steady, half and sparse ready, plus one long hold-off
  initial begin
    int mode;
    int stretch;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode    = $urandom_range(0, 2);
        stretch = $urandom_range(1, 40);
        for (int i = 0; i < stretch; i++) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic write_reg(input logic [afd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [afd_pkg::THRESH_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // one sample beat, then the burst pacing of the sender
  task automatic send_item(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic signed [15:0] z, input logic tmo);
    int gap;
    accel_x      <= x;
    accel_y      <= y;
    accel_z      <= z;
    timeout_flag <= tmo;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait until every result beat is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] jitter(input int center, input int span);
    return 16'(center + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic emit_run(input sample_kind_t kind, input int len, input tmo_mode_t tmode);
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               tmo;
    for (int i = 0; i < len && items_left > 0; i++) begin
      case (kind)
        SK_REST: begin
          x = jitter(0, 400);
          y = jitter(0, 400);
          z = ($urandom_range(0, 1) == 0) ? jitter(4096, 400) : jitter(-4096, 400);
        end
        SK_FREEFALL: begin
          x = jitter(0, 700);
          y = jitter(0, 700);
          z = jitter(0, 700);
        end
        SK_IMPACT: begin
          x = jitter(0, 32767);
          y = jitter(0, 32767);
          z = jitter(0, 32767);
        end
        default: begin
          x = 16'($urandom);
          y = 16'($urandom);
          z = 16'($urandom);
        end
      endcase
      case (tmode)
        TMO_RARE: tmo = ($urandom_range(0, 19) == 0);
        TMO_HALF: tmo = 1'($urandom_range(0, 1));
        default:  tmo = 1'b1;
      endcase
      send_item(x, y, z, tmo);
      items_left--;
    end
  endtask

  // mostly whole falls (rest, free fall, impact, rest); the rest timeouts and noise
  task automatic run_random(input int count);
    int choice;
    items_left = count;
    while (items_left > 0) begin
      choice = $urandom_range(0, 9);
      if (choice <= 6) begin
        emit_run(SK_REST, $urandom_range(4, 20), TMO_RARE);
        emit_run(SK_FREEFALL, $urandom_range(10, 40), TMO_RARE);
        emit_run(SK_IMPACT, $urandom_range(1, 8), TMO_RARE);
        emit_run(SK_REST, $urandom_range(4, 20), TMO_RARE);
      end else if (choice == 7) begin
        // free fall that times out before any impact
        emit_run(SK_FREEFALL, $urandom_range(10, 40), TMO_RARE);
        emit_run(SK_FREEFALL, $urandom_range(1, 4), TMO_ALWAYS);
        emit_run(SK_REST, $urandom_range(4, 20), TMO_HALF);
      end else if (choice == 8) begin
        emit_run(SK_WILD, $urandom_range(3, 15), TMO_HALF);
      end else begin
        emit_run(SK_REST, $urandom_range(3, 15), TMO_HALF);
      end
    end
  endtask

  initial begin
    logic [afd_pkg::THRESH_W-1:0] lo;
    logic [afd_pkg::THRESH_W-1:0] hi;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds; the ring starts as zeros so the first mean is low
    send_item(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_item(16'sd0, 16'sd0, 16'sd0, 1'b1);
    // idle to pre-fall and straight back out on timeout in one beat
    send_item(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_item(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    // fall and timeout on the same beat, fall wins
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
    // timeout while idle does nothing
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    send_item(16'sh8000, 16'sh7FFF, 16'sd0, 1'b0);
    send_item(16'sh7FFF, 16'sh8000, -16'sd1, 1'b1);
    send_item(-16'sd1, -16'sd1, -16'sd1, 1'b0);
    send_item(16'sd1, 16'sd0, 16'sd0, 1'b0);
    send_item(16'sd0, 16'sd0, 16'sh8000, 1'b1);
    run_random(120);
    settle();

    // every beat enters pre-fall and falls at once unless the mean is zero
    write_reg(afd_pkg::REG_LOW_THRESHOLD, 16'hFFFF);
    write_reg(afd_pkg::REG_HIGH_THRESHOLD, 16'h0000);
    run_random(60);
    settle();

    // pre-fall can never be entered
    write_reg(afd_pkg::REG_LOW_THRESHOLD, 16'h0000);
    write_reg(afd_pkg::REG_HIGH_THRESHOLD, 16'hFFFF);
    run_random(50);
    settle();

    for (int p = 0; p < 3; p++) begin
      lo = 16'($urandom_range(1000, 4000));
      hi = 16'($urandom_range(5000, 12000));
      write_reg(afd_pkg::REG_LOW_THRESHOLD, lo);
      write_reg(afd_pkg::REG_HIGH_THRESHOLD, hi);
      write_reg(REG_SPARE_A, 16'($urandom));
      write_reg(REG_SPARE_B, 16'($urandom));
      run_random(80);
      settle();
    end

    write_reg(afd_pkg::REG_LOW_THRESHOLD, afd_pkg::LOW_THRESHOLD_RESET);
    write_reg(afd_pkg::REG_HIGH_THRESHOLD, afd_pkg::HIGH_THRESHOLD_RESET);
    run_random(50);
    settle();

    if (errors == 0) begin
      $display("PASS accel_magnitude_fall_detector_core");
    end else begin
      $display("FAIL accel_magnitude_fall_detector_core");
    end
    $finish;
  end

endmodule
